// ===== src/tce_pkg.sv =====
// Package for the text console cursor engine: shared widths, character codes,
// defaults for the geometry parameters and the result structure.
// No dependencies.
package tce_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CharW  = 8;
  localparam int unsigned AttrW  = 8;
  localparam int unsigned AddrW  = 14;
  localparam int unsigned ValueW = 16;
  localparam int unsigned RowW   = 8;
  localparam int unsigned ColW   = 7;
  localparam int unsigned CurRowW = 5;

  // Default geometry.
  localparam int unsigned DefTextCols   = 80;
  localparam int unsigned DefScreenRows = 25;
  localparam int unsigned DefBufferRows = 200;

  // Control character codes.
  localparam logic [CharW-1:0] ChNewline   = 8'd10;
  localparam logic [CharW-1:0] ChReturn    = 8'd13;
  localparam logic [CharW-1:0] ChTab       = 8'd9;
  localparam logic [CharW-1:0] ChBackspace = 8'd8;
  localparam logic [CharW-1:0] ChSpace     = 8'd32;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgTextAttribute = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenEnable  = 2'd1;

  // Reset value of the text attribute register.
  localparam logic [AttrW-1:0] AttrReset = 8'd7;

  // Packed output stream width, rounded up to whole bytes.
  localparam int unsigned ResultBits = 1 + AddrW + ValueW + 1 + RowW + 1 + RowW
                                       + AddrW + AddrW;
  localparam int unsigned OutDataW   = ((ResultBits + 7) / 8) * 8;

  // One result item.
  typedef struct packed {
    logic [AddrW-1:0]  display_start_addr;
    logic [AddrW-1:0]  cursor_addr;
    logic [RowW-1:0]   clear_row;
    logic              clear_row_en;
    logic [RowW-1:0]   relocate_from_row;
    logic              relocate_en;
    logic [ValueW-1:0] cell_value;
    logic [AddrW-1:0]  cell_addr;
    logic              cell_write;
  } tce_result_t;

endpackage

// ===== src/tce_in_reg.sv =====
// Input register of the text console cursor engine: holds one accepted
// character until the cursor logic consumes it.
// Depends on tce_pkg.
module tce_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [tce_pkg::CharW-1:0] char_i,
  output logic                      valid_o,
  input  logic                      take_i,
  output logic [tce_pkg::CharW-1:0] char_o
);
  import tce_pkg::*;

  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q;
  logic             load;

  // The register frees up in the same cycle that its item is taken.
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Character payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

// ===== src/tce_cursor.sv =====
// Cursor state and update logic: decodes one character, moves the cursor,
// scrolls the screen and forms the result item. Row base addresses are
// kept incrementally so no multiplier is needed.
// Depends on tce_pkg.
module tce_cursor #(
  parameter int unsigned TextCols   = tce_pkg::DefTextCols,
  parameter int unsigned ScreenRows = tce_pkg::DefScreenRows,
  parameter int unsigned BufferRows = tce_pkg::DefBufferRows
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [tce_pkg::CharW-1:0] char_i,
  input  logic [tce_pkg::AttrW-1:0] attr_i,
  output tce_pkg::tce_result_t      result_o
);
  import tce_pkg::*;

  localparam logic [AddrW-1:0]   ColsStep   = AddrW'(TextCols);
  localparam logic [AddrW-1:0]   LastLine   = AddrW'((ScreenRows - 1) * TextCols);
  localparam logic [ColW:0]      ColsLim    = (ColW + 1)'(TextCols);
  localparam logic [CurRowW:0]   RowsLim    = (CurRowW + 1)'(ScreenRows);
  localparam logic [RowW:0]      StartMax   = (RowW + 1)'(BufferRows - ScreenRows);
  localparam logic [RowW-1:0]    ClearOff   = RowW'(ScreenRows - 1);

  logic [ColW-1:0]    col_q, col_d;
  logic [CurRowW-1:0] row_q, row_d;
  logic [RowW-1:0]    start_q, start_d;
  logic [AddrW-1:0]   line_q, line_d;
  logic [AddrW-1:0]   start_addr_q, start_addr_d;

  logic               move_down;
  logic [ColW:0]      col_next;
  logic [ColW:0]      tab_col;
  logic [RowW:0]      start_inc;
  logic [CurRowW:0]   row_inc;
  tce_result_t        res;

  // Character decode and column update.
  always_comb begin
    move_down = 1'b0;
    col_d     = col_q;
    res       = '0;
    col_next  = {1'b0, col_q} + 1'b1;
    tab_col   = {1'b0, col_q[ColW-1:3], 3'b000} + (ColW + 1)'(8);
    case (char_i)
      ChNewline: begin
        move_down = 1'b1;
        col_d     = '0;
      end
      ChReturn: begin
        col_d = '0;
      end
      ChTab: begin
        if (tab_col >= ColsLim) begin
          move_down = 1'b1;
          col_d     = '0;
        end else begin
          col_d = tab_col[ColW-1:0];
        end
      end
      ChBackspace: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end
        res.cell_write = 1'b1;
        res.cell_addr  = line_q + AddrW'(col_d);
        res.cell_value = {attr_i, ChSpace};
      end
      default: begin
        res.cell_write = 1'b1;
        res.cell_addr  = line_q + AddrW'(col_q);
        res.cell_value = {attr_i, char_i};
        if (col_next >= ColsLim) begin
          move_down = 1'b1;
          col_d     = '0;
        end else begin
          col_d = col_next[ColW-1:0];
        end
      end
    endcase

    // Row movement, scrolling and relocation.
    row_d        = row_q;
    start_d      = start_q;
    line_d       = line_q;
    start_addr_d = start_addr_q;
    row_inc      = {1'b0, row_q} + 1'b1;
    start_inc    = {1'b0, start_q} + 1'b1;
    if (move_down) begin
      if (row_inc >= RowsLim) begin
        if (start_inc > StartMax) begin
          res.relocate_en       = 1'b1;
          res.relocate_from_row = start_inc[RowW-1:0];
          start_d               = '0;
          start_addr_d          = '0;
          line_d                = LastLine;
        end else begin
          start_d      = start_inc[RowW-1:0];
          start_addr_d = start_addr_q + ColsStep;
          line_d       = line_q + ColsStep;
        end
        res.clear_row_en = 1'b1;
        res.clear_row    = start_d + ClearOff;
      end else begin
        row_d  = row_inc[CurRowW-1:0];
        line_d = line_q + ColsStep;
      end
    end

    res.cursor_addr        = line_d + AddrW'(col_d);
    res.display_start_addr = start_addr_d;
  end

  // Cursor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      start_q      <= '0;
      line_q       <= '0;
      start_addr_q <= '0;
    end else if (step_i) begin
      col_q        <= col_d;
      row_q        <= row_d;
      start_q      <= start_d;
      line_q       <= line_d;
      start_addr_q <= start_addr_d;
    end
  end

  assign result_o = res;

  // The cursor stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, row_q} < RowsLim) && ({1'b0, col_q} < ColsLim))
    else $error("cursor left the screen");

  // The start row never passes the last legal position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, start_q} <= StartMax)
    else $error("start row beyond buffer end");

  // The incremental line base matches the row and start row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q == AddrW'((32'(row_q) + 32'(start_q)) * TextCols))
    else $error("line base out of step with cursor row");

  // The display base matches the start row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_addr_q == AddrW'(32'(start_q) * TextCols))
    else $error("display base out of step with start row");

  // A relocation always comes with a row clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.relocate_en) |-> res.clear_row_en)
    else $error("relocation without row clear");

endmodule

// ===== src/tce_out_reg.sv =====
// Result register of the text console cursor engine: holds one result item
// and presents it to the output stream.
// Depends on tce_pkg.
module tce_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tce_pkg::tce_result_t result_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output tce_pkg::tce_result_t result_o
);
  import tce_pkg::*;

  logic        valid_q, valid_d;
  tce_result_t result_q;

  // Space is available when empty or when the held result leaves now.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== src/text_console_cursor_engine_core.sv =====
// Text console cursor engine. Takes one character per cycle on the input
// stream unless a stalled output holds it back, and gives one result per
// character while the screen is enabled (none while disabled). The character
// is held in the input register while the cursor update, a short add and
// compare path, forms the result; the result register then loads it and
// presents it on the output stream. A stalled output keeps the character in
// the input register and drops input ready in the same cycle.
// Attribute and enable are written through the configuration channel, which is
// always ready; unknown indexes are ignored.
// Depends on tce_pkg, tce_in_reg, tce_cursor and tce_out_reg.
module text_console_cursor_engine_core #(
  parameter int unsigned TextCols   = tce_pkg::DefTextCols,
  parameter int unsigned ScreenRows = tce_pkg::DefScreenRows,
  parameter int unsigned BufferRows = tce_pkg::DefBufferRows
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream. tdata: char_code[7:0].
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [tce_pkg::CharW-1:0]    s_axis_tdata,
  // Output stream. tdata from bit 0: cell_write, cell_addr[13:0],
  // cell_value[15:0], relocate_en, relocate_from_row[7:0], clear_row_en,
  // clear_row[7:0], cursor_addr[13:0], display_start_addr[13:0], zero fill.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tce_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tce_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tce_pkg::AttrW-1:0]    cfg_data_i
);
  import tce_pkg::*;

  logic             attr_wr;
  logic [AttrW-1:0] text_attr_q;
  logic             enable_q;
  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             out_free;
  logic             advance;
  logic             step;
  tce_result_t      cur_result;
  tce_result_t      out_result;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign attr_wr     = cfg_valid_i && (cfg_index_i == CfgTextAttribute);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= AttrReset;
      enable_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      if (attr_wr) begin
        text_attr_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgScreenEnable) begin
        enable_q <= cfg_data_i[0];
      end
    end
  end

  // A held character moves on when disabled, or when the result slot is free.
  assign advance = in_valid && (!enable_q || out_free);
  assign step    = advance && enable_q;

  tce_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .char_i  (s_axis_tdata),
    .valid_o (in_valid),
    .take_i  (advance),
    .char_o  (in_char)
  );

  tce_cursor #(
    .TextCols   (TextCols),
    .ScreenRows (ScreenRows),
    .BufferRows (BufferRows)
  ) u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (in_char),
    .attr_i   (text_attr_q),
    .result_o (cur_result)
  );

  tce_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .result_i (cur_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  // Pack the result into the output bus, lowest field first.
  assign m_axis_tdata = {(OutDataW - ResultBits)'(0), out_result};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the text console cursor engine: streams characters
// in, predicts every console update and compares it with the output stream.
// Depends on tce_pkg and text_console_cursor_engine_core.
module testbench;
  import tce_pkg::*;

  localparam int unsigned TextCols   = DefTextCols;
  localparam int unsigned ScreenRows = DefScreenRows;
  localparam int unsigned BufferRows = DefBufferRows;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned MaxPrinted = 40;
  localparam int unsigned PhaseItems = 141;
  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnmapped    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnmappedTop = 2'd3;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [CharW-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [AttrW-1:0]    cfg_data_i    = '0;

  text_console_cursor_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Characters waiting to be sent and console updates waiting to arrive.
  logic [CharW-1:0] char_backlog[$];
  tce_result_t      expected_updates[$];

  // Predicted console state and register copies.
  logic [ColW-1:0]    cur_col;
  logic [CurRowW-1:0] cur_row;
  logic [RowW-1:0]    top_row;
  logic [AttrW-1:0]   model_attr;
  logic               model_enable;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned chars_sent     = 0;
  int unsigned updates_seen   = 0;
  int unsigned scroll_count   = 0;
  int unsigned reloc_count    = 0;
  int unsigned quiet_cycles   = 0;

  tce_result_t got_update;
  tce_result_t want_update;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Buffer cell index of a screen row and column, cut to the address width.
  function automatic logic [AddrW-1:0] buffer_cell(input logic [CurRowW-1:0] row,
                                                   input logic [ColW-1:0] col);
    logic [31:0] idx;
    idx = (32'(row) + 32'(top_row)) * TextCols + 32'(col);
    return idx[AddrW-1:0];
  endfunction

  // Apply one character to the predicted console and queue the update it causes.
  function automatic void predict_console_update(input logic [CharW-1:0] ch);
    tce_result_t upd;
    logic        step_down;
    logic [31:0] start_addr;
    upd       = '0;
    step_down = 1'b0;
    if (!model_enable) return;
    if (ch == ChNewline) begin
      step_down = 1'b1;
    end else if (ch == ChReturn) begin
      cur_col = '0;
    end else if (ch == ChTab) begin
      cur_col = (cur_col & ~ColW'(7)) + ColW'(8);
      if (cur_col >= TextCols) step_down = 1'b1;
    end else if (ch == ChBackspace) begin
      if (cur_col > 0) cur_col = cur_col - 1'b1;
      upd.cell_write = 1'b1;
      upd.cell_addr  = buffer_cell(cur_row, cur_col);
      upd.cell_value = {model_attr, ChSpace};
    end else begin
      upd.cell_write = 1'b1;
      upd.cell_addr  = buffer_cell(cur_row, cur_col);
      upd.cell_value = {model_attr, ch};
      cur_col = cur_col + 1'b1;
      if (cur_col >= TextCols) step_down = 1'b1;
    end
    // Moving down past the last screen row scrolls, relocating at the buffer end.
    if (step_down) begin
      cur_row = cur_row + 1'b1;
      if (cur_row >= ScreenRows) begin
        top_row = top_row + 1'b1;
        scroll_count++;
        if (top_row > BufferRows - ScreenRows) begin
          upd.relocate_en       = 1'b1;
          upd.relocate_from_row = top_row;
          top_row = '0;
          reloc_count++;
        end
        upd.clear_row_en = 1'b1;
        upd.clear_row    = top_row + RowW'(ScreenRows - 1);
        cur_row = cur_row - 1'b1;
      end
      cur_col = '0;
    end
    start_addr = 32'(top_row) * TextCols;
    upd.cursor_addr        = buffer_cell(cur_row, cur_col);
    upd.display_start_addr = start_addr[AddrW-1:0];
    expected_updates.push_back(upd);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MaxPrinted)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Driver: presents characters from the backlog and predicts each accepted one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_console_update(s_axis_tdata);
        chars_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= char_backlog.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_update = m_axis_tdata[$bits(tce_result_t)-1:0];
        if (expected_updates.size() == 0) begin
          report_mismatch("unexpected transaction", got_update.cursor_addr, 0);
        end else begin
          want_update = expected_updates.pop_front();
          updates_seen++;
          if (got_update.cell_write !== want_update.cell_write)
            report_mismatch("cell_write", got_update.cell_write, want_update.cell_write);
          if (got_update.cell_addr !== want_update.cell_addr)
            report_mismatch("cell_addr", got_update.cell_addr, want_update.cell_addr);
          if (got_update.cell_value !== want_update.cell_value)
            report_mismatch("cell_value", got_update.cell_value, want_update.cell_value);
          if (got_update.relocate_en !== want_update.relocate_en)
            report_mismatch("relocate_en", got_update.relocate_en, want_update.relocate_en);
          if (got_update.relocate_from_row !== want_update.relocate_from_row)
            report_mismatch("relocate_from_row", got_update.relocate_from_row,
                            want_update.relocate_from_row);
          if (got_update.clear_row_en !== want_update.clear_row_en)
            report_mismatch("clear_row_en", got_update.clear_row_en,
                            want_update.clear_row_en);
          if (got_update.clear_row !== want_update.clear_row)
            report_mismatch("clear_row", got_update.clear_row, want_update.clear_row);
          if (got_update.cursor_addr !== want_update.cursor_addr)
            report_mismatch("cursor_addr", got_update.cursor_addr, want_update.cursor_addr);
          if (got_update.display_start_addr !== want_update.display_start_addr)
            report_mismatch("display_start_addr", got_update.display_start_addr,
                            want_update.display_start_addr);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("[%0t] no transaction for %0d cycles", $time, QuietLimit);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One register write transaction; the predicted copy follows on acceptance.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [AttrW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgTextAttribute) model_attr = val;
    else if (idx == CfgScreenEnable) model_enable = val[0];
  endtask

  // Wait until nothing is in flight, then let ignored characters pass through.
  task automatic drain_updates();
    while (char_backlog.size() != 0 || s_axis_tvalid || expected_updates.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Stimulus sequencer: directed characters, then phases of random text.
  initial begin
    int unsigned roll;
    cur_col      = '0;
    cur_row      = '0;
    top_row      = '0;
    model_attr   = AttrReset;
    model_enable = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every control code, backspace at column 0, tab wrap.
    char_backlog.push_back(8'h00);
    char_backlog.push_back(8'hFF);
    char_backlog.push_back(ChBackspace);
    char_backlog.push_back(ChBackspace);
    char_backlog.push_back(ChBackspace);
    char_backlog.push_back(8'h7F);
    char_backlog.push_back(8'h80);
    char_backlog.push_back(ChTab);
    char_backlog.push_back(8'h55);
    char_backlog.push_back(8'hAA);
    char_backlog.push_back(ChReturn);
    char_backlog.push_back(ChSpace);
    char_backlog.push_back(ChNewline);
    for (int i = 0; i < 11; i++) char_backlog.push_back(ChTab);

    for (int p = 0; p < 9; p++) begin
      drain_updates();
      case (p)
        0: write_register(CfgTextAttribute, 8'h00);
        1: write_register(CfgTextAttribute, 8'hFF);
        default: write_register(CfgTextAttribute, AttrW'($urandom_range(0, 255)));
      endcase
      write_register(CfgScreenEnable, (p == 4) ? AttrW'(0) : AttrW'(1));
      if (p == 2) write_register(CfgUnmapped, AttrW'($urandom_range(0, 255)));
      if (p == 6) write_register(CfgUnmappedTop, AttrW'($urandom_range(0, 255)));
      @(negedge clk_i);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      // Even phases are newline heavy to drive scrolling and relocation;
      // odd phases are mostly text so that lines wrap at the last column.
      for (int i = 0; i < ((p == 4) ? 16 : PhaseItems); i++) begin
        roll = $urandom_range(0, 99);
        if (p % 2 == 0) begin
          if (roll < 60)      char_backlog.push_back(ChNewline);
          else if (roll < 68) char_backlog.push_back(ChTab);
          else if (roll < 72) char_backlog.push_back(ChReturn);
          else if (roll < 76) char_backlog.push_back(ChBackspace);
          else                char_backlog.push_back(CharW'($urandom_range(0, 255)));
        end else begin
          if (roll < 3)       char_backlog.push_back(ChNewline);
          else if (roll < 10) char_backlog.push_back(ChTab);
          else if (roll < 12) char_backlog.push_back(ChReturn);
          else if (roll < 16) char_backlog.push_back(ChBackspace);
          else                char_backlog.push_back(CharW'($urandom_range(0, 255)));
        end
      end
    end

    drain_updates();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d characters and checked %0d console updates under four idle mixes.",
             chars_sent, updates_seen);
    $display("Predicted %0d scrolls and %0d buffer relocations; %0d mismatches.",
             scroll_count, reloc_count, mismatches);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
